// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the LED matrix row scanner RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define LMS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define LMS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/lms_pkg.sv =====
// ----------------------------------------------------------------------------
// lms_pkg
// Types and constants shared by the LED matrix row scanner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lms_pkg;

	// Request command codes
	localparam logic [1:0] CMD_PIXEL = 2'b00;
	localparam logic [1:0] CMD_FRAME = 2'b01;
	localparam logic [1:0] CMD_TICK  = 2'b10;

	// Frame geometry
	localparam int FRAME_W     = 32;
	localparam int FRAME_H     = 16;
	localparam int FRAME_SLOTS = 3;
	localparam int FRAME_DEPTH = FRAME_SLOTS * FRAME_W * FRAME_H;
	localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
	localparam int SECTION_W   = 8;
	localparam int LEVELS      = 4;
	localparam int COLORS      = 3;

	typedef logic [FRAME_AW-1:0] frame_addr_t;
	typedef logic [5:0]          pixel_t;
	typedef logic [1:0]          slot_t;

	// One section of a row: [color][level][pixel offset]
	typedef logic [COLORS-1:0][LEVELS-1:0][SECTION_W-1:0] plane_word_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clear_step;
		logic pixel_write;
		logic frame_done;
		logic tick_start;
		logic build_step;
		logic emit_step;
		logic advance;
	} lms_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic clear_last;
		logic build_last;
		logic emit_last;
		logic out_free;
		logic level_zero;
	} lms_status_t;

endpackage

`default_nettype wire

// ===== rtl/lms_ctrl.sv =====
// ----------------------------------------------------------------------------
// lms_ctrl
// Sequencer: memory clear, request decode, plane rebuild and row transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module lms_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           cmd,
	input  wire lms_pkg::lms_status_t st,
	output lms_pkg::lms_ctl_t         ctl
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_BUILD = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			ST_CLEAR: begin
				ctl.clear_step = 1'b1;
				if (st.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (cmd)
						lms_pkg::CMD_PIXEL: begin
							ctl.pixel_write = 1'b1;
						end
						lms_pkg::CMD_FRAME: begin
							ctl.frame_done = 1'b1;
						end
						lms_pkg::CMD_TICK: begin
							ctl.tick_start = 1'b1;
							state_d = st.level_zero ? ST_BUILD : ST_EMIT;
						end
						default: begin
						end
					endcase
				end
			end
			ST_BUILD: begin
				ctl.build_step = 1'b1;
				if (st.build_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				ctl.emit_step = st.out_free;
				if (st.out_free && st.emit_last) begin
					ctl.advance = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lms_datapath.sv =====
// ----------------------------------------------------------------------------
// lms_datapath
// Frame memory, slot rotation, scan position, row plane build and output
// register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lms_datapath #(
	parameter int SECTION_COUNT   = 8,
	parameter int SECTIONS_ACROSS = 4,
	parameter int SECTION_HEIGHT  = 8,
	parameter int SCAN_ROW_COUNT  = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lms_pkg::lms_ctl_t ctl,
	input  wire logic [4:0]        pixel_x,
	input  wire logic [3:0]        pixel_y,
	input  wire logic [5:0]        pixel_color,
	output lms_pkg::lms_status_t   st,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             out_byte,
	output logic                   row_start,
	output logic                   row_last
);

	localparam int SEC_W  = $clog2(SECTION_COUNT);
	localparam int SROW_W = $clog2(SECTION_COUNT);
	localparam int SCOL_W = (SECTIONS_ACROSS > 1) ? $clog2(SECTIONS_ACROSS) : 1;

	// Frame memory and slots
	lms_pkg::pixel_t      frame_mem [0:lms_pkg::FRAME_DEPTH-1];
	lms_pkg::pixel_t      rdata_q;
	lms_pkg::frame_addr_t clr_q;
	lms_pkg::frame_addr_t waddr;
	lms_pkg::frame_addr_t raddr;
	lms_pkg::pixel_t      wdata;
	logic                 we;
	lms_pkg::slot_t       fill_q;
	lms_pkg::slot_t       pending_q;
	lms_pkg::slot_t       shown_q;
	logic                 ready_q;

	// Scan position
	logic [2:0] scan_row_q;
	logic [1:0] level_q;
	logic [2:0] row_inc;
	logic       row_wrap;

	// Build walk
	logic [SEC_W-1:0]  b_sec_q;
	logic [2:0]        b_off_q;
	logic [SCOL_W-1:0] b_scol_q;
	logic [SROW_W-1:0] b_srow_q;
	logic              mirrored;
	logic [SCOL_W-1:0] scol_eff;
	logic [2:0]        off_eff;
	logic [6:0]        x_full;
	logic [7:0]        y_full;
	logic              in_frame;

	// Read pipeline and plane accumulation
	logic                 rd_s1;
	logic [2:0]           off_s1;
	logic [SEC_W-1:0]     sec_s1;
	logic                 inr_s1;
	lms_pkg::pixel_t      pix;
	logic [1:0]           inten;
	lms_pkg::plane_word_t work_q;
	lms_pkg::plane_word_t work_next;
	lms_pkg::plane_word_t plane_q [0:SECTION_COUNT-1];

	// Row transfer
	logic             e_first_q;
	logic [SEC_W-1:0] e_sec_q;
	logic [1:0]       e_col_q;
	logic [7:0]       byte_next;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             row_start_q;
	logic             row_last_q;

	// ---------------- frame memory ----------------
	assign we    = ctl.clear_step | ctl.pixel_write;
	assign waddr = ctl.clear_step ? clr_q : {fill_q, pixel_y, pixel_x};
	assign wdata = ctl.clear_step ? '0 : pixel_color;
	assign raddr = {shown_q, y_full[3:0], x_full[4:0]};

	always_ff @(posedge clk) begin
		if (we) begin
			frame_mem[waddr] <= wdata;
		end
		rdata_q <= frame_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clear_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// ---------------- slots and scan position ----------------
	assign row_inc  = scan_row_q + 3'd1;
	assign row_wrap = ({1'b0, row_inc} == 4'(SCAN_ROW_COUNT)) || (row_inc == 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= 2'd0;
			pending_q  <= 2'd1;
			shown_q    <= 2'd2;
			ready_q    <= 1'b0;
			scan_row_q <= 3'd0;
			level_q    <= 2'd0;
		end else if (ctl.frame_done) begin
			fill_q    <= pending_q;
			pending_q <= fill_q;
			ready_q   <= 1'b1;
		end else if (ctl.advance) begin
			level_q <= level_q + 2'd1;
			if (level_q == 2'd3) begin
				if (row_wrap) begin
					scan_row_q <= 3'd0;
					if (ready_q) begin
						shown_q   <= pending_q;
						pending_q <= shown_q;
						ready_q   <= 1'b0;
					end
				end else begin
					scan_row_q <= row_inc;
				end
			end
		end
	end

	// ---------------- build walk ----------------
	// Odd section rows run right to left across the panel
	assign mirrored = b_srow_q[0];
	assign scol_eff = mirrored ? (SCOL_W'(SECTIONS_ACROSS - 1) - b_scol_q) : b_scol_q;
	assign off_eff  = mirrored ? ~b_off_q : b_off_q;
	assign x_full   = (7'(scol_eff) << 3) | 7'(off_eff);
	assign y_full   = 8'(SECTION_HEIGHT) * 8'(b_srow_q) + 8'(scan_row_q);
	assign in_frame = (x_full < 7'(lms_pkg::FRAME_W)) && (y_full < 8'(lms_pkg::FRAME_H));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_sec_q  <= '0;
			b_off_q  <= '0;
			b_scol_q <= '0;
			b_srow_q <= '0;
		end else if (ctl.tick_start) begin
			b_sec_q  <= '0;
			b_off_q  <= '0;
			b_scol_q <= '0;
			b_srow_q <= '0;
		end else if (ctl.build_step) begin
			b_off_q <= b_off_q + 3'd1;
			if (b_off_q == 3'd7) begin
				b_sec_q <= b_sec_q + 1'b1;
				if (b_scol_q == SCOL_W'(SECTIONS_ACROSS - 1)) begin
					b_scol_q <= '0;
					b_srow_q <= b_srow_q + 1'b1;
				end else begin
					b_scol_q <= b_scol_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= ctl.build_step;
		end
	end

	always_ff @(posedge clk) begin
		off_s1 <= b_off_q;
		sec_s1 <= b_sec_q;
		inr_s1 <= in_frame;
	end

	// Light level 0 and 1 for any nonzero intensity, level 2 from 2 up, level 3 at 3
	always_comb begin
		pix       = inr_s1 ? rdata_q : '0;
		work_next = (off_s1 == 3'd0) ? '0 : work_q;
		inten     = 2'd0;
		for (int k = 0; k < lms_pkg::COLORS; k++) begin
			inten = pix[2*k +: 2];
			work_next[k][0][off_s1] = |inten;
			work_next[k][1][off_s1] = |inten;
			work_next[k][2][off_s1] = inten[1];
			work_next[k][3][off_s1] = &inten;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			work_q <= work_next;
			if (off_s1 == 3'd7) begin
				plane_q[sec_s1] <= work_next;
			end
		end
	end

	// ---------------- row transfer ----------------
	assign byte_next = e_first_q ? ~(8'd1 << scan_row_q) : plane_q[e_sec_q][e_col_q][level_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_first_q <= 1'b1;
			e_sec_q   <= '0;
			e_col_q   <= 2'd0;
		end else if (ctl.tick_start) begin
			e_first_q <= 1'b1;
			e_sec_q   <= '0;
			e_col_q   <= 2'd0;
		end else if (ctl.emit_step) begin
			if (e_first_q) begin
				e_first_q <= 1'b0;
			end else if (e_col_q == 2'd2) begin
				e_col_q <= 2'd0;
				e_sec_q <= e_sec_q + 1'b1;
			end else begin
				e_col_q <= e_col_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit_step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_step) begin
			out_byte_q  <= byte_next;
			row_start_q <= e_first_q;
			row_last_q  <= st.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign row_start = row_start_q;
	assign row_last  = row_last_q;

	// ---------------- status ----------------
	always_comb begin
		st            = '0;
		st.clear_last = (clr_q == lms_pkg::FRAME_AW'(lms_pkg::FRAME_DEPTH - 1));
		st.build_last = (b_sec_q == SEC_W'(SECTION_COUNT - 1)) && (b_off_q == 3'd7);
		st.emit_last  = !e_first_q && (e_sec_q == SEC_W'(SECTION_COUNT - 1))
			&& (e_col_q == 2'd2);
		st.out_free   = !out_valid_q || !out_stall;
		st.level_zero = (level_q == 2'd0);
	end

	`LMS_ASSERT(a_slots_distinct, clk, arst_n, (fill_q != pending_q) && (fill_q != shown_q) && (pending_q != shown_q), "frame slots collide")
	`LMS_ASSERT(a_build_ends, clk, arst_n, (rd_s1 && off_s1 == 3'd7 && sec_s1 == SEC_W'(SECTION_COUNT - 1)) |=> !rd_s1, "plane build ran past the last section")
	`LMS_ASSERT_NEVER(a_no_overwrite, clk, arst_n, ctl.emit_step && out_valid_q && out_stall, "output register overwritten while stalled")

endmodule

`default_nettype wire

// ===== rtl/led_matrix_row_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// led_matrix_row_scanner_unit
// Triple-buffered LED matrix row scanner with four PWM levels per channel.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------
//  in      | sink      | in_valid/in_stall  | cmd, pixel_x, pixel_y, pixel_color
//  out     | source    | out_valid/out_stall| out_byte, row_start, row_last
//
//  After reset all 1536 entries of the frame memory are cleared, one entry a
//  cycle, with in_stall high.
//  Pixel write, frame done and unused commands are taken without a stall.
//  A tick sends 1 + 3*SECTION_COUNT bytes, one a cycle when out_stall is low:
//  25 bytes with default parameters. A tick at level step 0 first rebuilds
//  the row planes from the shown frame, one pixel a cycle through the single
//  read port of the frame memory, 8*SECTION_COUNT pixels in all.
//  A stall on the output holds the transfer; the next request is taken while
//  the last byte still waits in the output register.
//
`default_nettype none
`include "assert_macros.svh"

module led_matrix_row_scanner_unit #(
	parameter int SECTION_COUNT   = 8,
	parameter int SECTIONS_ACROSS = 4,
	parameter int SECTION_HEIGHT  = 8,
	parameter int SCAN_ROW_COUNT  = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// request channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] cmd,
	input  wire logic [4:0] pixel_x,
	input  wire logic [3:0] pixel_y,
	input  wire logic [5:0] pixel_color,
	// byte stream to the panel shifter
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            row_start,
	output logic            row_last
);

	lms_pkg::lms_ctl_t    ctl;
	lms_pkg::lms_status_t st;

	// Sequencer: decode requests, step the clear, build and transfer phases
	lms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.st       (st),
		.ctl      (ctl)
	);

	// Frame store, row planes and output register
	lms_datapath #(
		.SECTION_COUNT   (SECTION_COUNT),
		.SECTIONS_ACROSS (SECTIONS_ACROSS),
		.SECTION_HEIGHT  (SECTION_HEIGHT),
		.SCAN_ROW_COUNT  (SCAN_ROW_COUNT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.st          (st),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.row_start   (row_start),
		.row_last    (row_last)
	);

	// The row select byte drives exactly one row low
	`LMS_ASSERT(a_row_select_one_cold, clk, arst_n, (out_valid && row_start) |-> ($countones(out_byte) == 7), "row select byte is not one-cold")

endmodule

`default_nettype wire
